### rtl/core/fixed_pool_free_list_allocator_core_macros.svh
// ----------------------------------------------------------------------------
// fixed pool free list allocator - assertion macros
// concurrent assertion shorthands with a common clock and reset
// ----------------------------------------------------------------------------
`ifndef FIXED_POOL_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_POOL_FREE_LIST_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication
`define FPFL_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fpfl same-cycle check failed");

// next-cycle implication
`define FPFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fpfl next-cycle check failed");

`endif

### rtl/core/fpfl_pkg.sv
// ----------------------------------------------------------------------------
// fpfl_pkg
// shared widths, codes and control structs of the free list allocator
// ----------------------------------------------------------------------------
`default_nettype none

package fpfl_pkg;

    localparam int FUNC_W         = 1;
    localparam int IDX_W          = 10;
    localparam int CNT_W          = 11;
    localparam int STATUS_W       = 2;
    localparam int POOL_DEPTH_DEF = 1024;
    localparam int COUNT_RESET    = 1024;

    localparam logic [FUNC_W-1:0] FUNC_ALLOC = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_BAD_INDEX = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic    clear_start;
        logic    clear_step;
        logic    push;
        logic    pop_read;
        logic    pop_done;
        logic    res_load;
        t_status res_code;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
        logic pool_empty;
        logic bad_index;
    } t_dp_stat;

endpackage

`default_nettype wire

### rtl/core/fpfl_ifs.sv
// ----------------------------------------------------------------------------
// fpfl request and response channels
// valid/ready channels carrying one request word and one response word
// ----------------------------------------------------------------------------
`default_nettype none

interface fpfl_req_if;
    logic                        valid;
    logic                        ready;
    logic [fpfl_pkg::FUNC_W-1:0] func;
    logic [fpfl_pkg::IDX_W-1:0]  free_index;

    modport source (output valid, output func, output free_index, input ready);
    modport sink   (input valid, input func, input free_index, output ready);
endinterface

interface fpfl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [fpfl_pkg::IDX_W-1:0]    slot_index;
    logic [fpfl_pkg::STATUS_W-1:0] status;

    modport source (output valid, output slot_index, output status, input ready);
    modport sink   (input valid, input slot_index, input status, output ready);
endinterface

`default_nettype wire

### rtl/core/fpfl_ram.sv
// ----------------------------------------------------------------------------
// fpfl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fpfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### rtl/core/fpfl_ctrl.sv
// ----------------------------------------------------------------------------
// fpfl_ctrl
// sequencer for link clearing, allocate and free, and response valid
// ----------------------------------------------------------------------------
`default_nettype none

module fpfl_ctrl (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic                        i_req_valid,
    input  wire logic [fpfl_pkg::FUNC_W-1:0] i_req_func,
    output logic                             o_req_ready,
    output logic                             o_rsp_valid,
    input  wire logic                        i_rsp_ready,
    input  wire fpfl_pkg::t_dp_stat          i_stat,
    output fpfl_pkg::t_dp_cmd                o_cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POP
    } t_state;

    t_state r_state;
    logic   r_rsp_valid;
    logic   w_accept;

    assign o_req_ready = (r_state == ST_IDLE) && (!r_rsp_valid || i_rsp_ready);
    assign w_accept    = i_req_valid && o_req_ready;

    always_comb begin
        o_cmd             = '0;
        o_cmd.res_code    = fpfl_pkg::STATUS_OK;
        o_cmd.clear_start = i_cfg_we;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear_step = 1'b1;
            end
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_req_func == fpfl_pkg::FUNC_FREE) begin
                        o_cmd.res_load = 1'b1;
                        if (i_stat.bad_index) begin
                            o_cmd.res_code = fpfl_pkg::STATUS_BAD_INDEX;
                        end else begin
                            o_cmd.push = 1'b1;
                        end
                    end else if (i_stat.pool_empty) begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_code = fpfl_pkg::STATUS_EMPTY;
                    end else begin
                        o_cmd.pop_read = 1'b1;
                    end
                end
            end
            ST_POP: begin
                o_cmd.pop_done = 1'b1;
                o_cmd.res_load = 1'b1;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rsp_valid <= 1'b0;
        end else begin
            if (o_cmd.res_load) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_state <= ST_CLEAR;
            end else begin
                case (r_state)
                    ST_CLEAR: begin
                        if (i_stat.clear_last) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    ST_IDLE: begin
                        if (o_cmd.pop_read) begin
                            r_state <= ST_POP;
                        end
                    end
                    ST_POP: begin
                        r_state <= ST_IDLE;
                    end
                    default: begin
                        r_state <= ST_CLEAR;
                    end
                endcase
            end
        end
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

### rtl/core/fpfl_dpath.sv
// ----------------------------------------------------------------------------
// fpfl_dpath
// head and count registers, link ram, clear counter and response word
// ----------------------------------------------------------------------------
`default_nettype none

module fpfl_dpath #(
    parameter int POOL_DEPTH = fpfl_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [fpfl_pkg::CNT_W-1:0]  i_cfg_data,
    input  wire fpfl_pkg::t_dp_cmd           i_cmd,
    input  wire logic [fpfl_pkg::IDX_W-1:0]  i_free_index,
    output fpfl_pkg::t_dp_stat               o_stat,
    output logic      [fpfl_pkg::IDX_W-1:0]  o_slot_index,
    output fpfl_pkg::t_status                o_status
);

    localparam int ADDR_W    = $clog2(POOL_DEPTH);
    localparam int LINK_W    = $clog2(POOL_DEPTH + 1);
    localparam int CMP_W     = (LINK_W > fpfl_pkg::IDX_W) ? LINK_W : fpfl_pkg::IDX_W;
    localparam int CLAMP_W   = (LINK_W > fpfl_pkg::CNT_W) ? LINK_W : fpfl_pkg::CNT_W;
    localparam int RST_COUNT = (fpfl_pkg::COUNT_RESET > POOL_DEPTH) ?
                               POOL_DEPTH : fpfl_pkg::COUNT_RESET;

    logic [LINK_W-1:0]          r_head, n_head;
    logic [LINK_W-1:0]          r_count, n_count;
    logic [ADDR_W-1:0]          r_clr_cnt, n_clr_cnt;
    logic [fpfl_pkg::IDX_W-1:0] r_slot;
    fpfl_pkg::t_status          r_status;

    logic [CLAMP_W-1:0] w_cfg_wide;
    logic [LINK_W-1:0]  w_cfg_count;
    logic               w_ram_we;
    logic [ADDR_W-1:0]  w_ram_waddr;
    logic [LINK_W-1:0]  w_ram_wdata;
    logic [LINK_W-1:0]  w_ram_rdata;

    // count write limited to 1..depth
    always_comb begin
        w_cfg_wide = CLAMP_W'(i_cfg_data);
        if (w_cfg_wide == '0) begin
            w_cfg_count = LINK_W'(1);
        end else if (w_cfg_wide > CLAMP_W'(POOL_DEPTH)) begin
            w_cfg_count = LINK_W'(POOL_DEPTH);
        end else begin
            w_cfg_count = LINK_W'(w_cfg_wide);
        end
    end

    always_comb begin
        n_count = i_cfg_we ? w_cfg_count : r_count;

        n_clr_cnt = r_clr_cnt;
        if (i_cmd.clear_start) begin
            n_clr_cnt = '0;
        end else if (i_cmd.clear_step) begin
            n_clr_cnt = r_clr_cnt + ADDR_W'(1);
        end

        n_head = r_head;
        if (i_cmd.clear_start) begin
            n_head = '0;
        end else if (i_cmd.pop_done) begin
            n_head = w_ram_rdata;
        end else if (i_cmd.push) begin
            n_head = LINK_W'(i_free_index);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_count   <= LINK_W'(RST_COUNT);
            r_clr_cnt <= '0;
        end else begin
            r_head    <= n_head;
            r_count   <= n_count;
            r_clr_cnt <= n_clr_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_status <= i_cmd.res_code;
            r_slot   <= i_cmd.pop_done ? fpfl_pkg::IDX_W'(r_head) : '0;
        end
    end

    // clearing writes entry i with i plus one, a free links the slot to the old head
    assign w_ram_we    = i_cmd.clear_step || i_cmd.push;
    assign w_ram_waddr = i_cmd.clear_step ? r_clr_cnt : ADDR_W'(i_free_index);
    assign w_ram_wdata = i_cmd.clear_step ? (LINK_W'(r_clr_cnt) + LINK_W'(1)) : r_head;

    fpfl_ram #(
        .WIDTH (LINK_W),
        .DEPTH (POOL_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_re    (i_cmd.pop_read),
        .i_raddr (ADDR_W'(r_head)),
        .o_rdata (w_ram_rdata)
    );

    assign o_stat.clear_last = (r_clr_cnt == ADDR_W'(POOL_DEPTH - 1));
    assign o_stat.pool_empty = (r_head >= r_count);
    assign o_stat.bad_index  = (CMP_W'(i_free_index) >= CMP_W'(r_count));

    assign o_slot_index = r_slot;
    assign o_status     = r_status;

endmodule

`default_nettype wire

### rtl/core/fixed_pool_free_list_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_pool_free_list_allocator_core
// lifo free list of equal-size slots: allocate pops the head, free pushes
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake          word
//  i_req     in   valid/ready        func, free_index
//  o_rsp     out  valid/ready        slot_index, status
//  i_cfg     in   we, no wait        pool_count (11 bits)
//
//  a free, or an allocate on an empty pool, loads the response word in the cycle it is taken
//  an allocate that pops goes through ST_POP: the link ram read at the head is registered
//  after reset and after every pool_count write a clearing pass rewrites the
//  link ram, one entry a cycle; no request word is taken then
//  the response register holds a word until o_rsp.ready; a new request is taken
//  in the cycle the pending word leaves
//
`default_nettype none

`include "fixed_pool_free_list_allocator_core_macros.svh"

module fixed_pool_free_list_allocator_core #(
    parameter int POOL_DEPTH = fpfl_pkg::POOL_DEPTH_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [fpfl_pkg::CNT_W-1:0] i_cfg_data,
    fpfl_req_if.sink                        i_req,
    fpfl_rsp_if.source                      o_rsp
);

    // command and status between sequencer and datapath
    fpfl_pkg::t_dp_cmd  w_cmd;
    fpfl_pkg::t_dp_stat w_stat;
    fpfl_pkg::t_status  w_res_status;

    // handshake terms for the checks below
    logic w_req_take;
    logic w_rsp_hold;

    // sequencer: clearing pass, request acceptance, pop wait, response valid
    fpfl_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_req_valid (i_req.valid),
        .i_req_func  (i_req.func),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: head, count, link ram and the response word
    fpfl_dpath #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .i_free_index (i_req.free_index),
        .o_stat       (w_stat),
        .o_slot_index (o_rsp.slot_index),
        .o_status     (w_res_status)
    );

    assign o_rsp.status = w_res_status;

    assign w_req_take = i_req.valid && i_req.ready;
    assign w_rsp_hold = o_rsp.valid && !o_rsp.ready;

    // no request word taken while the link ram is being cleared
    `FPFL_ASSERT_IMPL(a_no_accept_in_clear, i_clk, i_rst_n, w_cmd.clear_step, !w_req_take)
    // a pending response word is never overwritten
    `FPFL_ASSERT_IMPL(a_no_rsp_overwrite, i_clk, i_rst_n, w_rsp_hold, !w_cmd.res_load)
    // a pop read completes in the next cycle unless a pool_count write restarts clearing
    `FPFL_ASSERT_NEXT(a_pop_completes, i_clk, i_rst_n, w_cmd.pop_read && !i_cfg_we, w_cmd.pop_done)
    // a completing pop always pops a slot below the count
    `FPFL_ASSERT_IMPL(a_pop_not_empty, i_clk, i_rst_n, w_cmd.pop_done, !w_stat.pool_empty)

endmodule

`default_nettype wire
